@@ rtl/trilinear_volume_resampler_defines.svh @@
// Assertion macros shared by the resampler RTL.
// Included by the modules that carry concurrent checks; needs nothing else.
`ifndef TRILINEAR_VOLUME_RESAMPLER_DEFINES_SVH
`define TRILINEAR_VOLUME_RESAMPLER_DEFINES_SVH

// generic clocked check, disabled while the active-low reset is asserted
`define TVR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, bound to the usual i_clk / i_rst_n pair of this project
`define TVR_CHECK(label, prop, msg) \
    `TVR_ASSERT(label, i_clk, i_rst_n, prop, msg)

`endif

@@ rtl/tvr_pkg.sv @@
// Shared types and constants of the trilinear volume resampler.
// No dependencies; imported by the top level, front end, queue and back end.
package tvr_pkg;

    localparam int ADDR_W_DEF     = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int FIELD_W        = 24;   // holds any address or fraction width
    localparam int COORD_W        = 27;
    localparam int VALUE_W        = 16;
    localparam int GRAD_W         = 32;
    localparam int OUT_W          = 32;
    localparam int VOXEL_W        = VALUE_W + 3 * GRAD_W;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 27;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_ROW_LENGTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SLICE_LENGTH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_X_LOW        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_X_HIGH       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_Y_LOW        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_Y_HIGH       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_Z_LOW        = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_Z_HIGH       = 3'd7;

    localparam logic [10:0]               RST_ROW_LENGTH   = 11'd64;
    localparam logic [16:0]               RST_SLICE_LENGTH = 17'd4096;
    localparam logic signed [COORD_W-1:0] RST_X_LOW        = 27'sd0;
    localparam logic signed [COORD_W-1:0] RST_X_HIGH       = 27'sd4128768;
    localparam logic signed [COORD_W-1:0] RST_Y_LOW        = 27'sd0;
    localparam logic signed [COORD_W-1:0] RST_Y_HIGH       = 27'sd4128768;
    localparam logic signed [COORD_W-1:0] RST_Z_LOW        = 27'sd0;
    localparam logic signed [COORD_W-1:0] RST_Z_HIGH       = 27'sd983040;

    localparam logic [1:0] STATUS_PAD     = 2'd0;
    localparam logic [1:0] STATUS_OUTSIDE = 2'd1;
    localparam logic [1:0] STATUS_INSIDE  = 2'd2;

    typedef enum logic [1:0] {
        KIND_WRITE   = 2'd0,
        KIND_PAD     = 2'd1,
        KIND_OUTSIDE = 2'd2,
        KIND_INSIDE  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [10:0] row_length;
        logic [16:0] slice_length;
    } t_geom;

    typedef struct packed {
        t_kind                kind;
        logic [FIELD_W-1:0]   waddr;
        logic [VOXEL_W-1:0]   wdata;
        logic [FIELD_W-1:0]   ofs_x;
        logic [FIELD_W-1:0]   ofs_y;
        logic [FIELD_W-1:0]   ofs_z;
        logic [FIELD_W-1:0]   frac_x;
        logic [FIELD_W-1:0]   frac_y;
        logic [FIELD_W-1:0]   frac_z;
        logic signed [VALUE_W-1:0] target;
    } t_entry;

endpackage

@@ rtl/trilinear_volume_resampler.sv @@
// Trilinear volume resampler, top level.
// Depends on tvr_pkg, tvr_front, tvr_queue and tvr_back.
//
// Usage: load the source volume with write items (op 0: address, intensity,
// three gradients), then send sample items (op 1: Q.16 coordinate and target
// voxel). Each sample item gives one result; write items give none.
// Input channel: i_valid / o_stall, an item moves when valid is high and stall
// low. Output channel: o_valid / i_stall in the same way.
// Configuration: i_cfg_we with i_cfg_index / i_cfg_data, one register per edge,
// only while no item is in flight.
// Throughput: one item per cycle while the receiver does not stall, set by the
// eight corner reads done together on four dual-read copies of the voxel store.
// Path from input accept to result valid: the queue is written at the accept
// edge, then base index, addresses, store read, z, y, x blend, result register.
// Reset: synchronous, active low; clears the pipeline and queue and loads the
// register defaults. The voxel store is not cleared: unwritten voxels read
// as garbage. When the receiver stalls, the result is held and the whole
// back end freezes; the four-entry queue then fills and o_stall rises.
module trilinear_volume_resampler import tvr_pkg::*; #(
    parameter int VOLUME_ADDR_W  = ADDR_W_DEF,
    parameter int FRACTION_BITS  = FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_op,
    input  logic [15:0]               i_address,
    input  logic signed [VALUE_W-1:0] i_voxel_value,
    input  logic signed [GRAD_W-1:0]  i_grad_x_in,
    input  logic signed [GRAD_W-1:0]  i_grad_y_in,
    input  logic signed [GRAD_W-1:0]  i_grad_z_in,
    input  logic signed [COORD_W-1:0] i_coord_x,
    input  logic signed [COORD_W-1:0] i_coord_y,
    input  logic signed [COORD_W-1:0] i_coord_z,
    input  logic signed [VALUE_W-1:0] i_target_value,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [OUT_W-1:0]   o_intensity,
    output logic signed [OUT_W-1:0]   o_grad_x_out,
    output logic signed [OUT_W-1:0]   o_grad_y_out,
    output logic signed [OUT_W-1:0]   o_grad_z_out,
    output logic [1:0]                o_status
);

    t_entry front_entry;
    t_entry queue_entry;
    t_geom  geom;
    logic   push, pop, full, nonempty;

    tvr_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .i_op           (i_op),
        .i_address      (i_address),
        .i_voxel_value  (i_voxel_value),
        .i_grad_x_in    (i_grad_x_in),
        .i_grad_y_in    (i_grad_y_in),
        .i_grad_z_in    (i_grad_z_in),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_coord_z      (i_coord_z),
        .i_target_value (i_target_value),
        .i_full         (full),
        .o_stall        (o_stall),
        .o_push         (push),
        .o_entry        (front_entry),
        .o_geom         (geom)
    );

    tvr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_entry    (front_entry),
        .i_pop      (pop),
        .o_entry    (queue_entry),
        .o_full     (full),
        .o_nonempty (nonempty)
    );

    tvr_back #(
        .ADDR_W        (VOLUME_ADDR_W),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_geom       (geom),
        .i_entry      (queue_entry),
        .i_nonempty   (nonempty),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_intensity  (o_intensity),
        .o_grad_x_out (o_grad_x_out),
        .o_grad_y_out (o_grad_y_out),
        .o_grad_z_out (o_grad_z_out),
        .o_status     (o_status)
    );

endmodule

@@ rtl/tvr_ram.sv @@
// Generic single-write, dual-read RAM with registered read data.
// No dependencies; used for the voxel store copies.
module tvr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ rtl/tvr_lerp.sv @@
// One registered linear blend step, lo*(1-f) + hi*f, rounded half up.
// No package dependency; instanced by the back end for every blend stage.
module tvr_lerp #(
    parameter int VALUE_W       = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [VALUE_W-1:0] i_lo,
    input  logic signed [VALUE_W-1:0] i_hi,
    input  logic [FRACTION_BITS-1:0]  i_frac,
    output logic signed [VALUE_W-1:0] o_value
);

    localparam int SUM_W = VALUE_W + FRACTION_BITS + 2;

    logic signed [VALUE_W:0]   diff;
    logic signed [SUM_W-1:0]   prod;
    logic signed [SUM_W-1:0]   sum;
    logic signed [VALUE_W-1:0] r_value;

    // lo*one + (hi-lo)*f + half, then floor shift; result stays within [lo, hi]
    always_comb begin
        diff = $signed({i_hi[VALUE_W-1], i_hi}) - $signed({i_lo[VALUE_W-1], i_lo});
        prod = diff * $signed({1'b0, i_frac});
        sum  = $signed({{2{i_lo[VALUE_W-1]}}, i_lo, {FRACTION_BITS{1'b0}}}) + prod
             + $signed({{(VALUE_W+2){1'b0}}, 1'b1, {(FRACTION_BITS-1){1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= sum[VALUE_W+FRACTION_BITS-1:FRACTION_BITS];
        end
    end

    assign o_value = r_value;

endmodule

@@ rtl/tvr_queue.sv @@
// Small item queue between the front end and the back end.
// Depends on tvr_pkg for the entry type.
module tvr_queue import tvr_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_entry,
    output logic   o_full,
    output logic   o_nonempty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_entry    = r_mem[r_rd_ptr];
    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_nonempty = (r_count != '0);

endmodule

@@ rtl/tvr_front.sv @@
// Front end: configuration registers, item classification, integer/fraction
// split and row/slice offset products. Depends on tvr_pkg.
module tvr_front import tvr_pkg::*; #(
    parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                       i_valid,
    input  logic                       i_op,
    input  logic [15:0]                i_address,
    input  logic signed [VALUE_W-1:0]  i_voxel_value,
    input  logic signed [GRAD_W-1:0]   i_grad_x_in,
    input  logic signed [GRAD_W-1:0]   i_grad_y_in,
    input  logic signed [GRAD_W-1:0]   i_grad_z_in,
    input  logic signed [COORD_W-1:0]  i_coord_x,
    input  logic signed [COORD_W-1:0]  i_coord_y,
    input  logic signed [COORD_W-1:0]  i_coord_z,
    input  logic signed [VALUE_W-1:0]  i_target_value,
    input  logic                       i_full,
    output logic                       o_stall,
    output logic                       o_push,
    output t_entry                     o_entry,
    output t_geom                      o_geom
);

    logic [10:0]               r_row_length;
    logic [16:0]               r_slice_length;
    logic signed [COORD_W-1:0] r_x_low, r_x_high;
    logic signed [COORD_W-1:0] r_y_low, r_y_high;
    logic signed [COORD_W-1:0] r_z_low, r_z_high;

    logic signed [COORD_W-1:0]    int_x, int_y, int_z;
    logic signed [COORD_W+11:0]   prod_y;
    logic signed [COORD_W+17:0]   prod_z;
    logic                         in_bounds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length   <= RST_ROW_LENGTH;
            r_slice_length <= RST_SLICE_LENGTH;
            r_x_low        <= RST_X_LOW;
            r_x_high       <= RST_X_HIGH;
            r_y_low        <= RST_Y_LOW;
            r_y_high       <= RST_Y_HIGH;
            r_z_low        <= RST_Z_LOW;
            r_z_high       <= RST_Z_HIGH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ROW_LENGTH:   r_row_length   <= i_cfg_data[10:0];
                REG_SLICE_LENGTH: r_slice_length <= i_cfg_data[16:0];
                REG_X_LOW:        r_x_low        <= $signed(i_cfg_data);
                REG_X_HIGH:       r_x_high       <= $signed(i_cfg_data);
                REG_Y_LOW:        r_y_low        <= $signed(i_cfg_data);
                REG_Y_HIGH:       r_y_high       <= $signed(i_cfg_data);
                REG_Z_LOW:        r_z_low        <= $signed(i_cfg_data);
                REG_Z_HIGH:       r_z_high       <= $signed(i_cfg_data);
                default:          ;
            endcase
        end
    end

    always_comb begin
        // arithmetic shift gives floor for negative coordinates
        int_x  = i_coord_x >>> FRACTION_BITS;
        int_y  = i_coord_y >>> FRACTION_BITS;
        int_z  = i_coord_z >>> FRACTION_BITS;
        prod_y = int_y * $signed({1'b0, r_row_length});
        prod_z = int_z * $signed({1'b0, r_slice_length});
        in_bounds = (i_coord_x > r_x_low) && (i_coord_x < r_x_high)
                 && (i_coord_y > r_y_low) && (i_coord_y < r_y_high)
                 && (i_coord_z > r_z_low) && (i_coord_z < r_z_high);

        priority if (!i_op) begin
            o_entry.kind = KIND_WRITE;
        end else if (i_target_value < 0) begin
            o_entry.kind = KIND_PAD;
        end else if (in_bounds) begin
            o_entry.kind = KIND_INSIDE;
        end else begin
            o_entry.kind = KIND_OUTSIDE;
        end

        o_entry.waddr  = FIELD_W'(i_address);
        o_entry.wdata  = {i_grad_z_in, i_grad_y_in, i_grad_x_in, i_voxel_value};
        o_entry.ofs_x  = int_x[FIELD_W-1:0];
        o_entry.ofs_y  = prod_y[FIELD_W-1:0];
        o_entry.ofs_z  = prod_z[FIELD_W-1:0];
        o_entry.frac_x = FIELD_W'(i_coord_x[FRACTION_BITS-1:0]);
        o_entry.frac_y = FIELD_W'(i_coord_y[FRACTION_BITS-1:0]);
        o_entry.frac_z = FIELD_W'(i_coord_z[FRACTION_BITS-1:0]);
        o_entry.target = i_target_value;
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    assign o_geom.row_length   = r_row_length;
    assign o_geom.slice_length = r_slice_length;

endmodule

@@ rtl/tvr_back.sv @@
// Back end: neighbour addressing, voxel store (four dual-read copies),
// z/y/x blend pipeline and result register. Depends on tvr_pkg, tvr_ram,
// tvr_lerp and the assertion macros.
`include "trilinear_volume_resampler_defines.svh"
module tvr_back import tvr_pkg::*; #(
    parameter int ADDR_W        = ADDR_W_DEF,
    parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_geom                    i_geom,
    input  t_entry                   i_entry,
    input  logic                     i_nonempty,
    output logic                     o_pop,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [OUT_W-1:0]  o_intensity,
    output logic signed [OUT_W-1:0]  o_grad_x_out,
    output logic signed [OUT_W-1:0]  o_grad_y_out,
    output logic signed [OUT_W-1:0]  o_grad_z_out,
    output logic [1:0]               o_status
);

    localparam int VW = (VALUE_W + FRACTION_BITS > OUT_W) ? VALUE_W + FRACTION_BITS : OUT_W;
    localparam int FB = FRACTION_BITS;
    localparam logic signed [VW-1:0] MAX32 = VW'(64'sh7FFF_FFFF);
    localparam logic signed [VW-1:0] MIN32 = VW'(-64'sh8000_0000);
    localparam logic signed [VW-1:0] MINUS_ONE = VW'(-64'sd1) <<< FB;
    localparam logic signed [OUT_W-1:0] OUT_MINUS_ONE = OUT_W'(MINUS_ONE);

    function automatic logic signed [VW-1:0] chan(input logic [VOXEL_W-1:0] w, input int ch);
        logic signed [VW-1:0] v;
        if (ch == 0) begin
            v = VW'($signed(w[VALUE_W-1:0])) <<< FB;
        end else begin
            v = VW'($signed(w[VALUE_W + GRAD_W*(ch-1) +: GRAD_W]));
        end
        return v;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat32(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] t;
        t = v;
        if (v > MAX32) begin
            t = MAX32;
        end else if (v < MIN32) begin
            t = MIN32;
        end
        return t[OUT_W-1:0];
    endfunction

    logic en;

    // stage 1: linear base index
    logic                    r_s1_valid;
    t_kind                   r_s1_kind;
    logic [ADDR_W-1:0]       r_s1_base;
    logic [FB-1:0]           r_s1_fx, r_s1_fy, r_s1_fz;
    logic [ADDR_W-1:0]       r_s1_waddr;
    logic [VOXEL_W-1:0]      r_s1_wdata;
    logic signed [VALUE_W-1:0] r_s1_target;
    logic [FIELD_W-1:0]      base_sum;

    // stage 2: eight neighbour addresses, store access
    logic                    r_s2_valid;
    t_kind                   r_s2_kind;
    logic [ADDR_W-1:0]       r_s2_addr [4][2];
    logic [ADDR_W-1:0]       n_s2_addr [4][2];
    logic [FB-1:0]           r_s2_fx, r_s2_fy, r_s2_fz;
    logic [ADDR_W-1:0]       r_s2_waddr;
    logic [VOXEL_W-1:0]      r_s2_wdata;
    logic signed [VALUE_W-1:0] r_s2_target;
    logic [FIELD_W-1:0]      row_ext, slice_ext;

    // stage 3: corner data
    logic                    r_s3_valid;
    t_kind                   r_s3_kind;
    logic [FB-1:0]           r_s3_fx, r_s3_fy, r_s3_fz;
    logic signed [VALUE_W-1:0] r_s3_target;
    logic [VOXEL_W-1:0]      rd_a [4];
    logic [VOXEL_W-1:0]      rd_b [4];

    // stages 4 to 6: z, y, x blends
    logic                    r_s4_valid, r_s5_valid, r_s6_valid;
    t_kind                   r_s4_kind, r_s5_kind, r_s6_kind;
    logic [FB-1:0]           r_s4_fx, r_s4_fy, r_s5_fx;
    logic signed [VALUE_W-1:0] r_s4_target, r_s5_target, r_s6_target;
    logic signed [VW-1:0]    zv [4][4];
    logic signed [VW-1:0]    yv [4][2];
    logic signed [VW-1:0]    xv [4];

    // result register
    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_out_intensity, r_out_gx, r_out_gy, r_out_gz;
    logic [1:0]              r_out_status;

    assign en    = !r_out_valid || !i_stall;
    assign o_pop = en && i_nonempty;

    always_comb begin
        base_sum = i_entry.ofs_x + i_entry.ofs_y + i_entry.ofs_z;
    end

    always_comb begin
        row_ext   = FIELD_W'(i_geom.row_length);
        slice_ext = FIELD_W'(i_geom.slice_length);
        for (int k = 0; k < 4; k++) begin
            for (int dz = 0; dz < 2; dz++) begin
                n_s2_addr[k][dz] = r_s1_base + ADDR_W'(k % 2)
                                 + ((k >= 2) ? row_ext[ADDR_W-1:0] : '0)
                                 + ((dz == 1) ? slice_ext[ADDR_W-1:0] : '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_s6_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= i_nonempty;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_s5_valid  <= r_s4_valid;
            r_s6_valid  <= r_s5_valid;
            r_out_valid <= r_s6_valid && (r_s6_kind != KIND_WRITE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_kind   <= i_entry.kind;
            r_s1_base   <= base_sum[ADDR_W-1:0];
            r_s1_fx     <= i_entry.frac_x[FB-1:0];
            r_s1_fy     <= i_entry.frac_y[FB-1:0];
            r_s1_fz     <= i_entry.frac_z[FB-1:0];
            r_s1_waddr  <= i_entry.waddr[ADDR_W-1:0];
            r_s1_wdata  <= i_entry.wdata;
            r_s1_target <= i_entry.target;

            r_s2_kind   <= r_s1_kind;
            r_s2_addr   <= n_s2_addr;
            r_s2_fx     <= r_s1_fx;
            r_s2_fy     <= r_s1_fy;
            r_s2_fz     <= r_s1_fz;
            r_s2_waddr  <= r_s1_waddr;
            r_s2_wdata  <= r_s1_wdata;
            r_s2_target <= r_s1_target;

            r_s3_kind   <= r_s2_kind;
            r_s3_fx     <= r_s2_fx;
            r_s3_fy     <= r_s2_fy;
            r_s3_fz     <= r_s2_fz;
            r_s3_target <= r_s2_target;

            r_s4_kind   <= r_s3_kind;
            r_s4_fx     <= r_s3_fx;
            r_s4_fy     <= r_s3_fy;
            r_s4_target <= r_s3_target;

            r_s5_kind   <= r_s4_kind;
            r_s5_fx     <= r_s4_fx;
            r_s5_target <= r_s4_target;

            r_s6_kind   <= r_s5_kind;
            r_s6_target <= r_s5_target;

            unique case (r_s6_kind)
                KIND_INSIDE: begin
                    r_out_intensity <= sat32(xv[0]);
                    r_out_gx        <= sat32(xv[1]);
                    r_out_gy        <= sat32(xv[2]);
                    r_out_gz        <= sat32(xv[3]);
                    r_out_status    <= STATUS_INSIDE;
                end
                KIND_PAD: begin
                    r_out_intensity <= sat32(VW'(r_s6_target) <<< FB);
                    r_out_gx        <= '0;
                    r_out_gy        <= '0;
                    r_out_gz        <= '0;
                    r_out_status    <= STATUS_PAD;
                end
                default: begin
                    r_out_intensity <= OUT_MINUS_ONE;
                    r_out_gx        <= '0;
                    r_out_gy        <= '0;
                    r_out_gz        <= '0;
                    r_out_status    <= STATUS_OUTSIDE;
                end
            endcase
        end
    end

    // copy k serves corner (dx, dy) = (k%2, k/2); port a is dz=0, port b dz=1
    for (genvar k = 0; k < 4; k++) begin : g_store
        tvr_ram #(
            .WIDTH (VOXEL_W),
            .DEPTH (1 << ADDR_W)
        ) u_ram (
            .i_clk     (i_clk),
            .i_we      (en && r_s2_valid && (r_s2_kind == KIND_WRITE)),
            .i_waddr   (r_s2_waddr),
            .i_wdata   (r_s2_wdata),
            .i_re      (en),
            .i_raddr_a (r_s2_addr[k][0]),
            .i_raddr_b (r_s2_addr[k][1]),
            .o_rdata_a (rd_a[k]),
            .o_rdata_b (rd_b[k])
        );
    end

    for (genvar ch = 0; ch < 4; ch++) begin : g_ch
        for (genvar k = 0; k < 4; k++) begin : g_z
            tvr_lerp #(.VALUE_W(VW), .FRACTION_BITS(FB)) u_lerp (
                .i_clk   (i_clk),
                .i_en    (en),
                .i_lo    (chan(rd_a[k], ch)),
                .i_hi    (chan(rd_b[k], ch)),
                .i_frac  (r_s3_fz),
                .o_value (zv[ch][k])
            );
        end
        for (genvar dx = 0; dx < 2; dx++) begin : g_y
            tvr_lerp #(.VALUE_W(VW), .FRACTION_BITS(FB)) u_lerp (
                .i_clk   (i_clk),
                .i_en    (en),
                .i_lo    (zv[ch][dx]),
                .i_hi    (zv[ch][dx+2]),
                .i_frac  (r_s4_fy),
                .o_value (yv[ch][dx])
            );
        end
        tvr_lerp #(.VALUE_W(VW), .FRACTION_BITS(FB)) u_lerp_x (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_lo    (yv[ch][0]),
            .i_hi    (yv[ch][1]),
            .i_frac  (r_s5_fx),
            .o_value (xv[ch])
        );
    end

    assign o_valid      = r_out_valid;
    assign o_intensity  = r_out_intensity;
    assign o_grad_x_out = r_out_gx;
    assign o_grad_y_out = r_out_gy;
    assign o_grad_z_out = r_out_gz;
    assign o_status     = r_out_status;

    `TVR_CHECK(a_outside_value, r_out_valid && (r_out_status == STATUS_OUTSIDE) |-> (r_out_intensity == OUT_MINUS_ONE) && (r_out_gx == '0) && (r_out_gy == '0) && (r_out_gz == '0), "outside item with wrong result")
    `TVR_CHECK(a_pad_value, r_out_valid && (r_out_status == STATUS_PAD) |-> r_out_intensity[OUT_W-1] && (r_out_gx == '0) && (r_out_gy == '0) && (r_out_gz == '0), "padding item with wrong result")
    `TVR_CHECK(a_status_code, r_out_valid |-> (r_out_status == STATUS_PAD) || (r_out_status == STATUS_OUTSIDE) || (r_out_status == STATUS_INSIDE), "bad status code")
    `TVR_CHECK(a_write_silent, en && r_s6_valid && (r_s6_kind == KIND_WRITE) |=> !r_out_valid, "write item produced a result")

endmodule
